// ===== rtl/fsdr_pkg.sv =====
// Shared types, constants and helpers for the fused sparse-dense row kernel.
// Used by every module of the block; depends on nothing.
package fsdr_pkg;

    // Fixed geometry
    localparam int LANES         = 4;
    localparam int DATA_W        = 32;
    localparam int PROD_W        = 2 * DATA_W;
    localparam int VEC_LEN_DEF   = 4;
    localparam int FRAC_BITS_DEF = 16;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 32;

    // Register indexes
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_VECTOR = 3'd0;
    localparam t_cfg_idx CFG_REDUCE = 3'd1;
    localparam t_cfg_idx CFG_SCALE  = 3'd2;
    localparam t_cfg_idx CFG_ACCUM  = 3'd3;

    // Vector modes (unused codes act as copy lhs)
    typedef logic [2:0] t_vmode;
    localparam t_vmode VM_LHS = 3'd0;
    localparam t_vmode VM_RHS = 3'd1;
    localparam t_vmode VM_ADD = 3'd2;
    localparam t_vmode VM_SUB = 3'd3;
    localparam t_vmode VM_MAX = 3'd4;
    localparam t_vmode VM_MIN = 3'd5;

    // Reduce modes
    typedef logic [1:0] t_rmode;
    localparam t_rmode RM_ZERO = 2'd0;
    localparam t_rmode RM_DOT  = 2'd1;
    localparam t_rmode RM_LHS  = 2'd2;
    localparam t_rmode RM_TMP  = 2'd3;

    // Scale modes (unused code acts as none)
    typedef logic [1:0] t_smode;
    localparam t_smode SM_NONE = 2'd0;
    localparam t_smode SM_MUL  = 2'd1;
    localparam t_smode SM_ADD  = 2'd2;

    // Accumulate modes
    typedef logic [1:0] t_amode;
    localparam t_amode AM_NONE = 2'd0;
    localparam t_amode AM_ADD  = 2'd1;
    localparam t_amode AM_MAX  = 2'd2;
    localparam t_amode AM_MIN  = 2'd3;

    localparam logic signed [PROD_W-1:0] Q_MAX = PROD_W'(64'sd2147483647);
    localparam logic signed [PROD_W-1:0] Q_MIN = -PROD_W'(64'sd2147483648);

    typedef logic signed [DATA_W-1:0] t_data;

    // Saturated value and its clip flag
    typedef struct packed {
        t_data v;
        logic  clip;
    } t_sat;

    // Per-step strobes and modes from the sequencer
    typedef struct packed {
        logic   cap;
        logic   vec;
        logic   mul;
        logic   term;
        logic   sum;
        logic   scale;
        logic   scsat;
        logic   acc;
        logic   row_end;
        t_vmode vmode;
        t_rmode rmode;
        t_smode smode;
        t_amode amode;
    } t_lane_ctl;

    // What a lane shows to the merge stage and the sequencer
    typedef struct packed {
        t_data term;
        t_data t;
        t_data acc_next;
        logic  clip;
    } t_lane_out;

    // Clamp a wide signed value to the 32-bit range
    function automatic t_sat sat32(input logic signed [PROD_W-1:0] v);
        t_sat r;
        if (v > Q_MAX) begin
            r.v    = Q_MAX[DATA_W-1:0];
            r.clip = 1'b1;
        end else if (v < Q_MIN) begin
            r.v    = Q_MIN[DATA_W-1:0];
            r.clip = 1'b1;
        end else begin
            r.v    = v[DATA_W-1:0];
            r.clip = 1'b0;
        end
        return r;
    endfunction

endpackage

// ===== rtl/fsdr_lane.sv =====
// One element lane: vector op, shared multiplier, scale and accumulator.
// Depends on fsdr_pkg; stepped by the sequencer in the top level.
module fsdr_lane #(
    parameter int FRAC_BITS = fsdr_pkg::FRAC_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  fsdr_pkg::t_lane_ctl   i_ctl,
    input  fsdr_pkg::t_data       i_lhs,
    input  fsdr_pkg::t_data       i_rhs,
    input  fsdr_pkg::t_data       i_s,
    output fsdr_pkg::t_lane_out   o_out
);
    import fsdr_pkg::*;

    t_data                    r_lhs, r_rhs, r_t, r_term, r_acc;
    logic signed [PROD_W-1:0] r_prod;
    logic                     r_clip;

    t_sat  add_sat, sub_sat, prod_sat, scl_sat, acc_sat;
    t_data vec_t, mul_a, mul_b, acc_next;
    logic  vec_clip, acc_clip;

    // Saturating adders and the floored product
    always_comb begin
        add_sat  = sat32(PROD_W'(r_lhs) + PROD_W'(r_rhs));
        sub_sat  = sat32(PROD_W'(r_rhs) - PROD_W'(r_lhs));
        prod_sat = sat32(r_prod >>> FRAC_BITS);
        scl_sat  = sat32(PROD_W'(r_t) + PROD_W'(i_s));
        acc_sat  = sat32(PROD_W'(r_acc) + PROD_W'(r_t));
    end

    // Elementwise temp value
    always_comb begin
        vec_clip = 1'b0;
        case (i_ctl.vmode)
            VM_RHS: vec_t = r_rhs;
            VM_ADD: begin
                vec_t    = add_sat.v;
                vec_clip = add_sat.clip;
            end
            VM_SUB: begin
                vec_t    = sub_sat.v;
                vec_clip = sub_sat.clip;
            end
            VM_MAX:  vec_t = (r_lhs > r_rhs) ? r_lhs : r_rhs;
            VM_MIN:  vec_t = (r_lhs < r_rhs) ? r_lhs : r_rhs;
            default: vec_t = r_lhs;
        endcase
    end

    // Multiplier operands: lhs*T for the dot term, T*S for scaling
    assign mul_a = i_ctl.mul ? r_lhs : r_t;
    assign mul_b = i_ctl.mul ? r_t : i_s;

    // Fold T into the accumulator
    always_comb begin
        acc_clip = 1'b0;
        case (i_ctl.amode)
            AM_ADD: begin
                acc_next = acc_sat.v;
                acc_clip = acc_sat.clip;
            end
            AM_MAX:  acc_next = (r_acc > r_t) ? r_acc : r_t;
            AM_MIN:  acc_next = (r_acc < r_t) ? r_acc : r_t;
            default: acc_next = r_acc;
        endcase
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (i_ctl.cap) begin
            r_lhs <= i_lhs;
            r_rhs <= i_rhs;
        end
        if (i_ctl.vec) begin
            r_t    <= vec_t;
            r_clip <= vec_clip;
        end
        if (i_ctl.mul || i_ctl.scale) begin
            r_prod <= PROD_W'(mul_a) * PROD_W'(mul_b);
        end
        if (i_ctl.term) begin
            case (i_ctl.rmode)
                RM_DOT: begin
                    r_term <= prod_sat.v;
                    r_clip <= r_clip | prod_sat.clip;
                end
                RM_LHS:  r_term <= r_lhs;
                RM_TMP:  r_term <= r_t;
                default: r_term <= '0;
            endcase
        end
        if (i_ctl.scale && i_ctl.smode == SM_ADD) begin
            r_t    <= scl_sat.v;
            r_clip <= r_clip | scl_sat.clip;
        end
        if (i_ctl.scsat && i_ctl.smode == SM_MUL) begin
            r_t    <= prod_sat.v;
            r_clip <= r_clip | prod_sat.clip;
        end
    end

    // Row accumulator: cleared at reset and after each row end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else if (i_ctl.acc) begin
            r_acc <= i_ctl.row_end ? '0 : acc_next;
        end
    end

    assign o_out.term     = r_term;
    assign o_out.t        = r_t;
    assign o_out.acc_next = acc_next;
    assign o_out.clip     = r_clip | acc_clip;

endmodule

// ===== rtl/fsdr_merge.sv =====
// Merge stage: sums the lane terms into the saturated scalar S.
// Depends on fsdr_pkg; fed by the fsdr_lane instances.
module fsdr_merge #(
    parameter int VEC_LEN = fsdr_pkg::VEC_LEN_DEF
) (
    input  logic                 i_clk,
    input  fsdr_pkg::t_lane_ctl  i_ctl,
    input  fsdr_pkg::t_data      i_term [VEC_LEN],
    output fsdr_pkg::t_data      o_s,
    output logic                 o_clip
);
    import fsdr_pkg::*;

    localparam int SUM_W = DATA_W + $clog2(VEC_LEN) + 1;

    logic signed [SUM_W-1:0] sum;
    t_sat                    sum_sat;
    t_data                   r_s;
    logic                    r_clip;

    // Exact sum of the lane terms
    always_comb begin
        sum = '0;
        for (int k = 0; k < VEC_LEN; k++) begin
            sum = sum + SUM_W'(i_term[k]);
        end
        sum_sat = sat32(PROD_W'(sum));
    end

    // Hold S for the scale step
    always_ff @(posedge i_clk) begin
        if (i_ctl.sum) begin
            if (i_ctl.rmode == RM_ZERO) begin
                r_s    <= '0;
                r_clip <= 1'b0;
            end else begin
                r_s    <= sum_sat.v;
                r_clip <= sum_sat.clip;
            end
        end
    end

    assign o_s    = r_s;
    assign o_clip = r_clip;

endmodule

// ===== rtl/fused_sparse_dense_row_kernel.sv =====
// Fused sparse-dense row kernel: sequencer, configuration and result register.
// Depends on fsdr_pkg, fsdr_lane and fsdr_merge.
//
// Usage:
//   Input channel (i_valid / o_stall): one sparse nonzero per item, VEC_LEN
//   lhs and rhs elements in signed fixed point plus i_row_end.
//   Output channel (o_valid / i_stall): one item per row, the finished
//   accumulator lanes and the sticky clip flag, given on the row's last
//   nonzero. Lanes at or beyond VEC_LEN read zero.
//   Configuration (i_cfg_valid / o_cfg_ready): always ready; write only
//   while no item is in flight. Unknown indexes are ignored.
// Timing:
//   An item passes through the accept cycle and seven sequencer steps
//   (vector op, dot product, term saturate, lane merge, scale, scale
//   saturate, accumulate). Each lane's single multiplier is used twice per
//   item. A result appears on o_valid the cycle after the accumulate step.
//   o_stall is high from the vector op step to the accumulate step.
// Stall and reset:
//   A held result stays on the output while i_stall is high; the next item
//   is still taken and worked, and only a row end waits at the accumulate
//   step until the held result is taken. Reset clears the accumulators,
//   the clip flag, the configuration (accumulate mode add) and o_valid.
module fused_sparse_dense_row_kernel #(
    parameter int VEC_LEN   = fsdr_pkg::VEC_LEN_DEF,
    parameter int FRAC_BITS = fsdr_pkg::FRAC_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic signed [fsdr_pkg::DATA_W-1:0]   i_left_0,
    input  logic signed [fsdr_pkg::DATA_W-1:0]   i_left_1,
    input  logic signed [fsdr_pkg::DATA_W-1:0]   i_left_2,
    input  logic signed [fsdr_pkg::DATA_W-1:0]   i_left_3,
    input  logic signed [fsdr_pkg::DATA_W-1:0]   i_right_0,
    input  logic signed [fsdr_pkg::DATA_W-1:0]   i_right_1,
    input  logic signed [fsdr_pkg::DATA_W-1:0]   i_right_2,
    input  logic signed [fsdr_pkg::DATA_W-1:0]   i_right_3,
    input  logic                                 i_row_end,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic signed [fsdr_pkg::DATA_W-1:0]   o_acc_0,
    output logic signed [fsdr_pkg::DATA_W-1:0]   o_acc_1,
    output logic signed [fsdr_pkg::DATA_W-1:0]   o_acc_2,
    output logic signed [fsdr_pkg::DATA_W-1:0]   o_acc_3,
    output logic                                 o_clipped,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [fsdr_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [fsdr_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import fsdr_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_VEC, S_MUL, S_TERM, S_SUM, S_SCALE, S_SCSAT, S_ACC
    } t_state;

    t_state    r_state, n_state;
    t_vmode    r_vmode;
    t_rmode    r_rmode;
    t_smode    r_smode;
    t_amode    r_amode;
    logic      r_row_end, r_sticky, r_out_valid, r_clip_out;
    t_data     r_acc_out [LANES];
    t_lane_ctl ctl;
    t_lane_out lane_out [LANES];
    t_data     lhs [LANES];
    t_data     rhs [LANES];
    t_data     term [VEC_LEN];
    t_data     s_val;
    logic      merge_clip, accept, acc_go, item_clip;

    assign lhs = '{i_left_0, i_left_1, i_left_2, i_left_3};
    assign rhs = '{i_right_0, i_right_1, i_right_2, i_right_3};

    assign accept      = i_valid && (r_state == S_IDLE);
    assign o_stall     = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;

    // Hold a row end until the previous result is taken
    assign acc_go = (r_state == S_ACC) && !(r_row_end && r_out_valid && i_stall);

    // Step strobes
    always_comb begin
        ctl         = '0;
        ctl.cap     = accept;
        ctl.vec     = (r_state == S_VEC);
        ctl.mul     = (r_state == S_MUL);
        ctl.term    = (r_state == S_TERM);
        ctl.sum     = (r_state == S_SUM);
        ctl.scale   = (r_state == S_SCALE);
        ctl.scsat   = (r_state == S_SCSAT);
        ctl.acc     = acc_go;
        ctl.row_end = r_row_end;
        ctl.vmode   = r_vmode;
        ctl.rmode   = r_rmode;
        ctl.smode   = r_smode;
        ctl.amode   = r_amode;
    end

    // Lanes
    for (genvar k = 0; k < LANES; k++) begin : g_lane
        if (k < VEC_LEN) begin : g_on
            fsdr_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctl   (ctl),
                .i_lhs   (lhs[k]),
                .i_rhs   (rhs[k]),
                .i_s     (s_val),
                .o_out   (lane_out[k])
            );
            assign term[k] = lane_out[k].term;
        end else begin : g_off
            assign lane_out[k] = '0;
        end
    end

    fsdr_merge #(.VEC_LEN(VEC_LEN)) u_merge (
        .i_clk  (i_clk),
        .i_ctl  (ctl),
        .i_term (term),
        .o_s    (s_val),
        .o_clip (merge_clip)
    );

    // Clip events of this item, lanes and merge together
    always_comb begin
        item_clip = merge_clip;
        for (int k = 0; k < LANES; k++) begin
            item_clip = item_clip | lane_out[k].clip;
        end
    end

    // Sequencer next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (i_valid) n_state = S_VEC;
            S_VEC:   n_state = S_MUL;
            S_MUL:   n_state = S_TERM;
            S_TERM:  n_state = S_SUM;
            S_SUM:   n_state = S_SCALE;
            S_SCALE: n_state = S_SCSAT;
            S_SCSAT: n_state = S_ACC;
            S_ACC:   if (acc_go) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // State, sticky flag and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_sticky    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (acc_go) begin
                r_sticky <= r_row_end ? 1'b0 : (r_sticky | item_clip);
            end
            if (acc_go && r_row_end) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
        if (accept) begin
            r_row_end <= i_row_end;
        end
        if (acc_go && r_row_end) begin
            r_clip_out <= r_sticky | item_clip;
            for (int k = 0; k < LANES; k++) begin
                r_acc_out[k] <= lane_out[k].acc_next;
            end
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vmode <= VM_LHS;
            r_rmode <= RM_ZERO;
            r_smode <= SM_NONE;
            r_amode <= AM_ADD;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_VECTOR: r_vmode <= i_cfg_data[2:0];
                CFG_REDUCE: r_rmode <= i_cfg_data[1:0];
                CFG_SCALE:  r_smode <= i_cfg_data[1:0];
                CFG_ACCUM:  r_amode <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    assign o_valid   = r_out_valid;
    assign o_acc_0   = r_acc_out[0];
    assign o_acc_1   = r_acc_out[1];
    assign o_acc_2   = r_acc_out[2];
    assign o_acc_3   = r_acc_out[3];
    assign o_clipped = r_clip_out;

endmodule

// ===== rtl/fsdr_checker.sv =====
// Port-level checks for the fused sparse-dense row kernel, bound to the top.
// Depends on fsdr_pkg and fused_sparse_dense_row_kernel.
module fsdr_checker (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    input  logic                                 o_stall,
    input  logic                                 o_valid,
    input  logic                                 i_stall,
    input  logic signed [fsdr_pkg::DATA_W-1:0]   o_acc_0,
    input  logic signed [fsdr_pkg::DATA_W-1:0]   o_acc_1,
    input  logic signed [fsdr_pkg::DATA_W-1:0]   o_acc_2,
    input  logic signed [fsdr_pkg::DATA_W-1:0]   o_acc_3,
    input  logic                                 o_clipped,
    input  logic                                 o_cfg_ready
);
    import fsdr_pkg::*;

    // Hold a stalled result item
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_acc_0) && $stable(o_acc_1)
            && $stable(o_acc_2) && $stable(o_acc_3) && $stable(o_clipped)))
        else $error("stalled result item changed");

    // An accepted item keeps the input side busy next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("input not held off after accepting an item");

    // A new result only comes out of an item in flight
    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(o_stall))
        else $error("result item appeared with no item in flight");

    // Configuration port never pushes back
    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cfg_ready)
        else $error("configuration port not ready");

endmodule

bind fused_sparse_dense_row_kernel fsdr_checker u_fsdr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_valid     (i_valid),
    .o_stall     (o_stall),
    .o_valid     (o_valid),
    .i_stall     (i_stall),
    .o_acc_0     (o_acc_0),
    .o_acc_1     (o_acc_1),
    .o_acc_2     (o_acc_2),
    .o_acc_3     (o_acc_3),
    .o_clipped   (o_clipped),
    .o_cfg_ready (o_cfg_ready)
);
